>>> src/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  // Smallest and largest accepted base
  localparam logic [7:0] RADIX_MIN = 8'd2;
  localparam logic [7:0] RADIX_MAX = 8'd36;

  // ASCII anchors for digit glyphs
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_LOW_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_NONE  = 8'h00;
  localparam logic [5:0] DEC_DIGITS = 6'd10;
  localparam logic [5:0] ALL_DIGITS = 6'd36;

  // Input word
  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic [7:0]  base;
  } in_t;

  // Output word
  typedef struct packed {
    logic [7:0] digit_char;
    logic       minus_first;
    logic       last;
    logic       bad_base;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;       // capture operand, clear digit count
    logic step;        // one restoring division step
    logic ptr_init;    // point read pointer at most significant digit
    logic load_digit;  // move stored digit into output register
    logic load_bad;    // load the error word
  } itrd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_bad;     // base of the presented input word is out of range
    logic step_last;  // current step is the final one of this division
    logic quot_zero;  // running quotient is zero
    logic cnt_full;   // digit store is full
    logic ptr_zero;   // read pointer is at the least significant digit
    logic out_free;   // output register can take a word this cycle
  } itrd_status_t;

  // Digit value to lower-case ASCII
  function automatic logic [7:0] digit_glyph(input logic [5:0] d);
    logic [7:0] g;
    if (d < DEC_DIGITS) begin
      g = CHAR_ZERO + {2'b00, d};
    end else if (d < ALL_DIGITS) begin
      g = CHAR_LOW_A + {2'b00, d - DEC_DIGITS};
    end else begin
      g = CHAR_NONE;
    end
    return g;
  endfunction

endpackage

>>> src/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: runs one bit-serial division per digit, then reads the stored
// digits back most significant first into the output register.
// ----------------------------------------------------------------------------
module itrd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  itrd_pkg::itrd_status_t status_i,
  output itrd_pkg::itrd_cmd_t    cmd_o
);
  import itrd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_RD,
    ST_LOAD,
    ST_BAD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.in_bad) begin
            state_d = ST_BAD;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.step_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // stop once the quotient runs out or the store is full
        if (status_i.quot_zero || status_i.cnt_full) begin
          cmd_o.ptr_init = 1'b1;
          state_d        = ST_RD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_RD: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_digit = 1'b1;
          state_d          = status_i.ptr_zero ? ST_IDLE : ST_RD;
        end
      end
      ST_BAD: begin
        if (status_i.out_free) begin
          cmd_o.load_bad = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // Digits are only loaded after a store read state has filled the read data register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_digit |-> $past(state_q) == ST_RD || $past(state_q) == ST_LOAD)
    else $error("digit load without a preceding store read");

  // A division always runs to its final step before the quotient is checked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> $past(status_i.step_last) && $past(state_q) == ST_DIV)
    else $error("quotient check before division finished");

  // New words are never taken while a conversion is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !in_ready_o)
    else $error("ready while converting");
`endif

endmodule

>>> src/itrd_dpath.sv
// ----------------------------------------------------------------------------
// itrd_dpath
// Operand capture with sign handling, restoring shift-subtract divider,
// digit store and output register.
// ----------------------------------------------------------------------------
module itrd_dpath #(
  parameter int VALUE_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  itrd_pkg::in_t          in_data_i,
  input  itrd_pkg::itrd_cmd_t    cmd_i,
  output itrd_pkg::itrd_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output itrd_pkg::out_t         out_data_o
);
  import itrd_pkg::*;

  localparam int IDXW  = $clog2(VALUE_BITS);
  localparam int CNTW  = $clog2(VALUE_BITS + 1);
  localparam int STEPW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] v_in, mag_in;
  logic                  neg_in;

  logic [VALUE_BITS-1:0] quot_q;
  logic [5:0]            rem_q;
  logic [5:0]            base_q;
  logic                  neg_q;
  logic                  first_q;
  logic [STEPW-1:0]      step_q;
  logic [CNTW-1:0]       cnt_q;
  logic [IDXW-1:0]       ptr_q;

  logic [6:0]            rem_sh;
  logic                  rem_ge;
  logic [5:0]            rem_next;

  logic [5:0]            store_mem [VALUE_BITS];
  logic [5:0]            rd_data_q;

  out_t                  out_q;
  logic                  out_valid_q;
  logic                  step_last;

  // Operand magnitude and sign
  assign v_in   = in_data_i.value[VALUE_BITS-1:0];
  assign neg_in = in_data_i.is_signed && v_in[VALUE_BITS-1];
  assign mag_in = neg_in ? (~v_in + 1'b1) : v_in;

  // One restoring division step
  assign rem_sh   = {rem_q, quot_q[VALUE_BITS-1]};
  assign rem_ge   = rem_sh >= {1'b0, base_q};
  assign rem_next = rem_ge ? 6'(rem_sh - {1'b0, base_q}) : rem_sh[5:0];

  assign step_last = (step_q == STEPW'(VALUE_BITS - 1));

  // Status to controller
  assign status_o.in_bad    = (in_data_i.base < RADIX_MIN) || (in_data_i.base > RADIX_MAX);
  assign status_o.step_last = step_last;
  assign status_o.quot_zero = (quot_q == '0);
  assign status_o.cnt_full  = (cnt_q == CNTW'(VALUE_BITS));
  assign status_o.ptr_zero  = (ptr_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Divider, counters and pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q  <= '0;
      rem_q   <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
      ptr_q   <= '0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        quot_q  <= mag_in;
        rem_q   <= '0;
        step_q  <= '0;
        cnt_q   <= '0;
        first_q <= 1'b1;
      end else if (cmd_i.step) begin
        quot_q <= {quot_q[VALUE_BITS-2:0], rem_ge};
        if (step_last) begin
          rem_q  <= '0;
          step_q <= '0;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          rem_q  <= rem_next;
          step_q <= step_q + 1'b1;
        end
      end
      if (cmd_i.ptr_init) begin
        ptr_q <= IDXW'(cnt_q - 1'b1);
      end else if (cmd_i.load_digit) begin
        ptr_q   <= ptr_q - 1'b1;
        first_q <= 1'b0;
      end
    end
  end

  // Base and sign capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      base_q <= in_data_i.base[5:0];
      neg_q  <= neg_in;
    end
  end

  // Digit store: remainder written at the end of each division
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && step_last) begin
      store_mem[cnt_q[IDXW-1:0]] <= rem_next;
    end
    rd_data_q <= store_mem[ptr_q];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_digit || cmd_i.load_bad) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_bad) begin
      out_q.digit_char  <= CHAR_NONE;
      out_q.minus_first <= 1'b0;
      out_q.last        <= 1'b1;
      out_q.bad_base    <= 1'b1;
    end else if (cmd_i.load_digit) begin
      out_q.digit_char  <= digit_glyph(rd_data_q);
      out_q.minus_first <= first_q && neg_q;
      out_q.last        <= (ptr_q == '0);
      out_q.bad_base    <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Remainder must stay below the base throughout a division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> rem_q < base_q)
    else $error("division remainder reached the base");

  // The output register is never overwritten while a word still waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_digit || cmd_i.load_bad) |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

  // No division starts with the digit store already full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> cnt_q < CNTW'(VALUE_BITS))
    else $error("digit store overflow");
`endif

endmodule

>>> src/integer_to_radix_digits.sv
// Each digit takes one full division and a quotient check; read back takes a store
// read and an output load per digit.
// Throughput: one word at a time; the next is taken once the last digit is in
// the output register. The serial divider (one quotient bit per cycle) sets it.
// A bad base puts its error word in the output register from ST_BAD, once that register is free.
// Reset: asynchronous, active low; clears control state, the digit store is not cleared.
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an integer to lower-case ASCII digits in base 2 to 36, most
// significant digit first, flagging a leading minus for negative signed input.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
  parameter int VALUE_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itrd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output itrd_pkg::out_t out_data_o
);
  import itrd_pkg::*;

  itrd_cmd_t    cmd;
  itrd_status_t status;

  // Sequencer
  itrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Divider, digit store and output register
  itrd_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/tb_integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits
// Self-checking bench for the radix digit converter. A directed table covers
// the zero operand, field extremes, the most negative signed operand, minus
// flagging and out-of-range bases. A long random run follows. Every accepted
// input word without a typed result is expanded by a local digit predictor into the queue of digit
// words it must produce, and each output word is checked against its queue entry field by
// field. Both handshakes idle at random; the bench includes one long output
// stall followed by a full drain.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits;
  timeunit 1ns;
  timeprecision 1ps;

  import itrd_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 112;
  localparam int unsigned PRESSURE_WORDS = 6;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned DRAIN_CYCLES   = 200;
  // A 64 digit conversion runs with no handshake until its first digit word
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [8*36-1:0] GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

  // One directed word, with its single result typed in where it is obvious
  typedef struct {
    in_t  word;
    bit   typed;
    out_t result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  out_t        digits_due[$];
  stim_row_t   directed_rows[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned digits_seen;
  int unsigned bad_seen;
  int unsigned minus_seen;
  bit          tx_no_idle;
  bit          rx_no_idle;
  bit          rx_hold_req;

  integer_to_radix_digits u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic in_t in_word(input logic [63:0] v, input logic sgn, input logic [7:0] b);
    in_t w;
    w.value     = v;
    w.is_signed = sgn;
    w.base      = b;
    return w;
  endfunction

  function automatic out_t out_word(input logic [7:0] ch, input logic m, input logic l,
                                    input logic b);
    out_t r;
    r.digit_char  = ch;
    r.minus_first = m;
    r.last        = l;
    r.bad_base    = b;
    return r;
  endfunction

  // Expand one accepted word into its digit words, most significant first
  function automatic void predict_digits(input in_t w);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem_full;
    logic [5:0]  rems [0:63];
    logic        neg;
    int          n;
    int          k;
    int          d;
    if (w.base < RADIX_MIN || w.base > RADIX_MAX) begin
      digits_due.push_back(out_word(CHAR_NONE, 1'b0, 1'b1, 1'b1));
      return;
    end
    mag   = w.value;
    neg   = w.is_signed && mag[63];
    // Negation of the most negative value leaves 2^63, read as unsigned
    if (neg) mag = -mag;
    radix = {56'd0, w.base};
    n     = 0;
    if (mag == 64'd0) begin
      rems[0] = 6'd0;
      n       = 1;
    end
    while (mag != 64'd0) begin
      rem_full = mag % radix;
      rems[n]  = rem_full[5:0];
      mag      = mag / radix;
      n++;
    end
    for (k = n - 1; k >= 0; k--) begin
      d = rems[k];
      digits_due.push_back(out_word(GLYPHS[8*(35-d) +: 8], neg && (k == n - 1),
                                    k == 0, 1'b0));
    end
  endfunction

  function automatic logic [63:0] pick_value();
    int unsigned sh;
    sh = $urandom_range(0, 63);
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 1000));
      2:       return (64'd1 << sh) - 64'($urandom_range(0, 1));
      3:       return ALL_ONES - 64'($urandom_range(0, 40));
      4:       return MOST_NEG + 64'($urandom_range(0, 40));
      default: return 64'($urandom) << sh;
    endcase
  endfunction

  // Mostly valid bases, now and then one out of range on either side
  function automatic in_t random_word();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0)
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(37, 255));
    else
      b = 8'($urandom_range(RADIX_MIN, RADIX_MAX));
    return in_word(pick_value(), 1'($urandom_range(0, 1)), b);
  endfunction

  function automatic int unsigned draw_gap(input bit none);
    return none ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic add_row(input in_t w, input bit typed, input out_t r);
    stim_row_t row;
    row.word   = w;
    row.typed  = typed;
    row.result = r;
    directed_rows.push_back(row);
  endtask

  // Offer one word from a falling edge; returns on the falling edge after acceptance
  task automatic drive_word(input in_t w, input int unsigned gap, input bit typed,
                            input out_t r);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (typed) digits_due.push_back(r);
    else predict_digits(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    $display("%0d ns: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
    errors++;
  endtask

  // Output checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digits_due.size() == 0) begin
        $display("%0d ns: unexpected digit word, actual %p", $time, out_data_o);
        errors++;
      end else begin
        want = digits_due.pop_front();
        if (out_data_o.digit_char !== want.digit_char)
          report_field("digit_char", want.digit_char, out_data_o.digit_char);
        if (out_data_o.minus_first !== want.minus_first)
          report_field("minus_first", 8'(want.minus_first), 8'(out_data_o.minus_first));
        if (out_data_o.last !== want.last)
          report_field("last", 8'(want.last), 8'(out_data_o.last));
        if (out_data_o.bad_base !== want.bad_base)
          report_field("bad_base", 8'(want.bad_base), 8'(out_data_o.bad_base));
      end
      digits_seen++;
      if (out_data_o.bad_base === 1'b1) bad_seen++;
      if (out_data_o.minus_first === 1'b1) minus_seen++;
    end
  end

  // Output side: random stalls per word, one long hold on request
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(rx_no_idle);
      if (rx_hold_req) begin
        gap         = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0d ns: no handshake for %0d cycles, %0d digit words outstanding",
             $time, WATCHDOG_LIMIT, digits_due.size());
    $display("tb_integer_to_radix_digits: errors");
    $finish;
  end

  // Stimulus
  initial begin
    out_t nil;
    nil         = out_word(CHAR_NONE, 1'b0, 1'b0, 1'b0);
    errors      = 0;
    words_sent  = 0;
    digits_seen = 0;
    bad_seen    = 0;
    minus_seen  = 0;
    tx_no_idle  = 1'b0;
    rx_no_idle  = 1'b0;
    rx_hold_req = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;

    //      operand                  signed base     typed  expected word
    add_row(in_word(64'd0,          1'b0, 8'd10),  1'b1, out_word(CHAR_ZERO, 1'b0, 1'b1, 1'b0));
    add_row(in_word(64'd0,          1'b1, 8'd2),   1'b1, out_word(CHAR_ZERO, 1'b0, 1'b1, 1'b0));
    add_row(in_word(ALL_ONES,       1'b1, 8'd10),  1'b1, out_word("1", 1'b1, 1'b1, 1'b0));
    add_row(in_word(64'd35,         1'b0, 8'd36),  1'b1, out_word("z", 1'b0, 1'b1, 1'b0));
    add_row(in_word(64'd10,         1'b1, 8'd36),  1'b1, out_word(CHAR_LOW_A, 1'b0, 1'b1, 1'b0));
    add_row(in_word(64'd9,          1'b0, 8'd10),  1'b1, out_word("9", 1'b0, 1'b1, 1'b0));
    add_row(in_word(64'd1,          1'b1, 8'd2),   1'b1, out_word("1", 1'b0, 1'b1, 1'b0));
    add_row(in_word(64'd77,         1'b0, 8'd0),   1'b1, out_word(CHAR_NONE, 1'b0, 1'b1, 1'b1));
    add_row(in_word(ALL_ONES,       1'b1, 8'd1),   1'b1, out_word(CHAR_NONE, 1'b0, 1'b1, 1'b1));
    add_row(in_word(64'd5,          1'b0, 8'd37),  1'b1, out_word(CHAR_NONE, 1'b0, 1'b1, 1'b1));
    add_row(in_word(MOST_NEG,       1'b1, 8'd255), 1'b1, out_word(CHAR_NONE, 1'b0, 1'b1, 1'b1));
    add_row(in_word(64'd0,          1'b0, 8'h80),  1'b1, out_word(CHAR_NONE, 1'b0, 1'b1, 1'b1));
    add_row(in_word(ALL_ONES,       1'b0, 8'd2),   1'b0, nil);
    add_row(in_word(ALL_ONES,       1'b0, 8'd36),  1'b0, nil);
    add_row(in_word(MOST_NEG,       1'b1, 8'd2),   1'b0, nil);
    add_row(in_word(MOST_NEG,       1'b1, 8'd10),  1'b0, nil);
    add_row(in_word(MOST_NEG,       1'b0, 8'd16),  1'b0, nil);
    add_row(in_word(MOST_POS,       1'b1, 8'd36),  1'b0, nil);
    add_row(in_word(ALL_ONES - 1,   1'b1, 8'd3),   1'b0, nil);
    add_row(in_word(64'h0123_4567_89AB_CDEF, 1'b0, 8'd16), 1'b0, nil);
    add_row(in_word(64'd36,         1'b0, 8'd36),  1'b0, nil);
    add_row(in_word(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 8'd7), 1'b0, nil);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (directed_rows[i])
      drive_word(directed_rows[i].word, draw_gap(1'b0), directed_rows[i].typed,
                 directed_rows[i].result);

    // Long output stall while words keep coming, then a full drain
    rx_hold_req = 1'b1;
    repeat (PRESSURE_WORDS) drive_word(random_word(), 0, 1'b0, nil);
    in_valid_i <= 1'b0;
    while (digits_due.size() != 0) @(negedge clk_i);

    // Random words, with one stretch of back-to-back traffic on both sides
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_no_idle = (i >= 50 && i < 75);
      rx_no_idle = tx_no_idle;
      drive_word(random_word(), draw_gap(tx_no_idle), 1'b0, nil);
    end
    in_valid_i <= 1'b0;
    rx_no_idle = 1'b0;

    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d words into %0d checked digit words", words_sent, digits_seen);
    $display("including %0d bad-base words and %0d minus-flagged results", bad_seen,
             minus_seen);
    if (errors == 0) begin
      $display("tb_integer_to_radix_digits: clean");
    end else begin
      $display("tb_integer_to_radix_digits: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/itrd_pkg.sv
src/itrd_ctrl.sv
src/itrd_dpath.sv
src/integer_to_radix_digits.sv
verif/tb_integer_to_radix_digits.sv
